### rtl/core/tfl_pkg.sv
package tfl_pkg;

  // reset values of the configuration registers
  localparam logic [15:0] TC_RESET  = 16'd10;
  localparam logic [15:0] GAP_RESET = 16'd300;

  // register select values of address bit 2 (registers are word aligned)
  localparam logic REG_TC  = 1'b0;
  localparam logic REG_GAP = 1'b1;

  typedef enum logic [1:0] {
    OUTC_FILTERED = 2'd0,
    OUTC_HELD     = 2'd1,
    OUTC_RESTART  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered;
    logic [1:0]         outcome;
  } out_item_t;

  // datapath operations issued by the sequencer
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DEN,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_P,
    OP_MUL_Q,
    OP_ACC,
    OP_EMIT_HELD,
    OP_EMIT_RESTART,
    OP_EMIT_FILT
  } op_t;

  // branch conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_NO_INPUT,
    CND_ZERO_DT,
    CND_LONG_GAP,
    CND_DIV_BUSY,
    CND_OUT_BUSY
  } cond_t;

  localparam int PC_W = 4;

  // program step addresses
  localparam logic [PC_W-1:0] ST_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] ST_DEN      = 4'd1;
  localparam logic [PC_W-1:0] ST_DIV_INIT = 4'd2;
  localparam logic [PC_W-1:0] ST_DIV      = 4'd3;
  localparam logic [PC_W-1:0] ST_MUL_P    = 4'd4;
  localparam logic [PC_W-1:0] ST_MUL_Q    = 4'd5;
  localparam logic [PC_W-1:0] ST_ACC      = 4'd6;
  localparam logic [PC_W-1:0] ST_HELD     = 4'd7;
  localparam logic [PC_W-1:0] ST_RESTART  = 4'd8;
  localparam logic [PC_W-1:0] ST_FILT     = 4'd9;

  // one microcode word: operation, branch condition, taken and fall-through targets;
  // with hold set a taken branch also suppresses the operation (stall)
  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic             hold;
    logic [PC_W-1:0]  jump;
    logic [PC_W-1:0]  next;
  } ucw_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic zero_dt;
    logic long_gap;
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

### rtl/core/tfl_seq.sv
module tfl_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  tfl_pkg::sts_t sts,
  output tfl_pkg::ctl_t ctl
);

  logic [tfl_pkg::PC_W-1:0] pc_r;
  logic [tfl_pkg::PC_W-1:0] pc_nxt;
  tfl_pkg::ucw_t            ucw;
  logic                     taken;

  // microcode rom
  function automatic tfl_pkg::ucw_t rom(input logic [tfl_pkg::PC_W-1:0] pc);
    tfl_pkg::ucw_t w;
    w = '{tfl_pkg::OP_NONE, tfl_pkg::CND_NEVER, 1'b0, tfl_pkg::ST_WAIT, tfl_pkg::ST_WAIT};
    case (pc)
      tfl_pkg::ST_WAIT:
        w = '{tfl_pkg::OP_LOAD, tfl_pkg::CND_NO_INPUT, 1'b1,
              tfl_pkg::ST_WAIT, tfl_pkg::ST_DEN};
      tfl_pkg::ST_DEN:
        w = '{tfl_pkg::OP_DEN, tfl_pkg::CND_ZERO_DT, 1'b0,
              tfl_pkg::ST_HELD, tfl_pkg::ST_DIV_INIT};
      tfl_pkg::ST_DIV_INIT:
        w = '{tfl_pkg::OP_DIV_INIT, tfl_pkg::CND_LONG_GAP, 1'b0,
              tfl_pkg::ST_RESTART, tfl_pkg::ST_DIV};
      tfl_pkg::ST_DIV:
        w = '{tfl_pkg::OP_DIV_STEP, tfl_pkg::CND_DIV_BUSY, 1'b0,
              tfl_pkg::ST_DIV, tfl_pkg::ST_MUL_P};
      tfl_pkg::ST_MUL_P:
        w = '{tfl_pkg::OP_MUL_P, tfl_pkg::CND_NEVER, 1'b0,
              tfl_pkg::ST_MUL_Q, tfl_pkg::ST_MUL_Q};
      tfl_pkg::ST_MUL_Q:
        w = '{tfl_pkg::OP_MUL_Q, tfl_pkg::CND_NEVER, 1'b0,
              tfl_pkg::ST_ACC, tfl_pkg::ST_ACC};
      tfl_pkg::ST_ACC:
        w = '{tfl_pkg::OP_ACC, tfl_pkg::CND_NEVER, 1'b0,
              tfl_pkg::ST_FILT, tfl_pkg::ST_FILT};
      tfl_pkg::ST_HELD:
        w = '{tfl_pkg::OP_EMIT_HELD, tfl_pkg::CND_OUT_BUSY, 1'b1,
              tfl_pkg::ST_HELD, tfl_pkg::ST_WAIT};
      tfl_pkg::ST_RESTART:
        w = '{tfl_pkg::OP_EMIT_RESTART, tfl_pkg::CND_OUT_BUSY, 1'b1,
              tfl_pkg::ST_RESTART, tfl_pkg::ST_WAIT};
      tfl_pkg::ST_FILT:
        w = '{tfl_pkg::OP_EMIT_FILT, tfl_pkg::CND_OUT_BUSY, 1'b1,
              tfl_pkg::ST_FILT, tfl_pkg::ST_WAIT};
      default:
        w = '{tfl_pkg::OP_NONE, tfl_pkg::CND_NEVER, 1'b0,
              tfl_pkg::ST_WAIT, tfl_pkg::ST_WAIT};
    endcase
    return w;
  endfunction

  always_comb begin
    ucw = rom(pc_r);
    case (ucw.cond)
      tfl_pkg::CND_NEVER:    taken = 1'b0;
      tfl_pkg::CND_NO_INPUT: taken = !sts.in_valid;
      tfl_pkg::CND_ZERO_DT:  taken = sts.zero_dt;
      tfl_pkg::CND_LONG_GAP: taken = sts.long_gap;
      tfl_pkg::CND_DIV_BUSY: taken = sts.div_busy;
      tfl_pkg::CND_OUT_BUSY: taken = sts.out_busy;
      default:               taken = 1'b0;
    endcase
    pc_nxt   = taken ? ucw.jump : ucw.next;
    ctl.op   = ucw.op;
    ctl.fire = !(ucw.hold && taken);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tfl_pkg::ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### rtl/core/tfl_dp.sv
module tfl_dp #(
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tfl_pkg::ctl_t      ctl,
  input  tfl_pkg::in_item_t  in_data,
  input  logic [15:0]        tc,
  input  logic [15:0]        gap,
  input  logic               out_ready,
  output logic               out_valid,
  output tfl_pkg::out_item_t out_data,
  output tfl_pkg::sts_t      sts
);

  localparam int F  = ALPHA_FRAC_BITS;
  localparam int QW = F + 1;             // alpha in [0, 2^F]
  localparam int NW = F + 17;            // dividend width
  localparam int CW = $clog2(F + 1);
  localparam int PW = 32 + QW;           // product width
  localparam int AW = 34 + F;            // accumulator width
  localparam logic [QW-1:0] ONE  = QW'(1) << F;
  localparam logic [AW-1:0] HALF = AW'(1) << (F - 1);

  logic [31:0]  x_r;
  logic [31:0]  now_r;
  logic [31:0]  dt_r;
  logic [16:0]  den_r;
  logic [16:0]  rem_r;
  logic [QW-1:0] numlo_r;
  logic [QW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] prod_r;
  logic [AW-1:0] acc_r;
  logic [31:0]  last_output_r;
  logic [31:0]  last_time_r;
  logic         out_valid_r;
  tfl_pkg::out_item_t out_r;

  logic [NW-1:0] num;
  logic [17:0]   trial;
  logic          qbit;
  logic [16:0]   rem_nxt;
  logic [31:0]   p_word;
  logic [31:0]   q_word;
  logic [AW-F-1:0] shifted;
  logic [31:0]   y_word;
  logic          emit;

  always_comb begin
    num     = {1'b0, tc, F'(0)} + NW'(den_r >> 1);
    trial   = {rem_r, numlo_r[QW-1]};
    qbit    = trial >= {1'b0, den_r};
    rem_nxt = qbit ? 17'(trial - {1'b0, den_r}) : trial[16:0];
    // offset binary: value + 2^31
    p_word  = {~last_output_r[31], last_output_r[30:0]};
    q_word  = {~x_r[31], x_r[30:0]};
    shifted = acc_r[AW-1:F];
    y_word  = (shifted[AW-F-1:32] != '0) ? 32'hFFFF_FFFF : shifted[31:0];
    y_word  = {~y_word[31], y_word[30:0]};
    emit    = ctl.fire && ((ctl.op == tfl_pkg::OP_EMIT_HELD) ||
                           (ctl.op == tfl_pkg::OP_EMIT_RESTART) ||
                           (ctl.op == tfl_pkg::OP_EMIT_FILT));
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      case (ctl.op)
        tfl_pkg::OP_LOAD: begin
          x_r   <= in_data.sample;
          now_r <= in_data.now_ms;
          dt_r  <= in_data.now_ms - last_time_r;
        end
        tfl_pkg::OP_DEN: begin
          den_r <= {1'b0, tc} + {1'b0, dt_r[15:0]};
        end
        tfl_pkg::OP_DIV_INIT: begin
          rem_r   <= {1'b0, num[NW-1:QW]};
          numlo_r <= num[QW-1:0];
          quo_r   <= '0;
          cnt_r   <= CW'(F);
        end
        tfl_pkg::OP_DIV_STEP: begin
          rem_r   <= rem_nxt;
          numlo_r <= numlo_r << 1;
          quo_r   <= {quo_r[QW-2:0], qbit};
          cnt_r   <= cnt_r - CW'(1);
        end
        tfl_pkg::OP_MUL_P: begin
          prod_r <= PW'(quo_r) * PW'(p_word);
          acc_r  <= HALF;
        end
        tfl_pkg::OP_MUL_Q: begin
          acc_r  <= acc_r + AW'(prod_r);
          prod_r <= PW'(ONE - quo_r) * PW'(q_word);
        end
        tfl_pkg::OP_ACC: begin
          acc_r <= acc_r + AW'(prod_r);
        end
        tfl_pkg::OP_EMIT_HELD: begin
          out_r.filtered <= last_output_r;
          out_r.outcome  <= tfl_pkg::OUTC_HELD;
        end
        tfl_pkg::OP_EMIT_RESTART: begin
          out_r.filtered <= x_r;
          out_r.outcome  <= tfl_pkg::OUTC_RESTART;
        end
        tfl_pkg::OP_EMIT_FILT: begin
          out_r.filtered <= y_word;
          out_r.outcome  <= tfl_pkg::OUTC_FILTERED;
        end
        default: begin
        end
      endcase
    end
  end

  // filter state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_output_r <= '0;
      last_time_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.fire && (ctl.op == tfl_pkg::OP_EMIT_RESTART)) begin
        last_output_r <= x_r;
        last_time_r   <= now_r;
      end else if (ctl.fire && (ctl.op == tfl_pkg::OP_EMIT_FILT)) begin
        last_output_r <= y_word;
        last_time_r   <= now_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.in_valid = 1'b0;
  assign sts.zero_dt  = (dt_r == '0);
  assign sts.long_gap = (dt_r > {16'b0, gap});
  assign sts.div_busy = (cnt_r != '0);
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

### rtl/core/timed_first_order_lowpass_core.sv
// first-order low-pass filter with a variable time step. each input transaction
// carries a signed q16.16 sample and a wrapping millisecond tick; the block keeps
// the last output and the tick of the last update. dt = now_ms - last tick (mod 2^32).
// dt of zero returns the held value (outcome 1, state unchanged); dt above max_gap_ms
// restarts from the raw sample (outcome 2); otherwise alpha = tc/(tc+dt) is formed as
// an ALPHA_FRAC_BITS fraction by a restoring divider and y = alpha*y_prev +
// (1-alpha)*x, rounded to nearest (outcome 0). one transaction is processed at a
// time, stepped by the microcoded sequencer: a filtered result goes through wait,
// den, div_init, div (the divider yields one quotient bit per cycle), mul_p, mul_q,
// acc and filt into the output register; a held result goes through wait, den and
// held, and a restart through wait, den, div_init and restart. the next transaction
// is taken in the wait step that follows the emit step.
// the output register lets the next transaction be accepted while a result waits.
// registers via the apb port: 0x0 time_constant_ms (reset 10), 0x4 max_gap_ms
// (reset 300); write them only while the block is idle.
module timed_first_order_lowpass_core #(
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  tfl_pkg::in_item_t  in_data,
  // result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output tfl_pkg::out_item_t out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0]   tc_r;
  logic [15:0]   gap_r;
  tfl_pkg::ctl_t ctl;
  tfl_pkg::sts_t dp_sts;
  tfl_pkg::sts_t sts;
  logic          cfg_wr;

  // apb registers, written in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r  <= tfl_pkg::TC_RESET;
      gap_r <= tfl_pkg::GAP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == tfl_pkg::REG_TC) begin
        tc_r <= pwdata[15:0];
      end else begin
        gap_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == tfl_pkg::REG_TC) ? {16'b0, tc_r} : {16'b0, gap_r};

  // the wait step is the only one that takes a transaction
  assign in_ready = (ctl.op == tfl_pkg::OP_LOAD);

  // merge handshake status into what the datapath reports
  always_comb begin
    sts          = dp_sts;
    sts.in_valid = in_valid;
  end

  // microcode sequencer: step counter, rom and branch logic
  tfl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // datapath: dt, divider, multiplier, accumulator, output register
  tfl_dp #(
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .tc        (tc_r),
    .gap       (gap_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (dp_sts)
  );

endmodule

### bench/tb_timed_first_order_lowpass_core.sv
module tb_timed_first_order_lowpass_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;              // alpha fraction bits, same as the instance
  localparam int SETTLE_CYCLES = 40;     // longer than a filtered transaction
  localparam int HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
  localparam int NUM_PHASES = 12;

  // register byte addresses, bit 2 selects the register
  localparam logic [2:0] ADDR_TC  = {tfl_pkg::REG_TC, 2'b00};
  localparam logic [2:0] ADDR_GAP = {tfl_pkg::REG_GAP, 2'b00};

  // predicts the filter output for each accepted sample and checks results in order
  class lowpass_scoreboard;
    logic [15:0] tc;
    logic [15:0] gap;
    logic [31:0] y_last;
    logic [31:0] t_last;
    tfl_pkg::out_item_t predicted_outputs[$];
    int          errors;

    function new();
      tc = tfl_pkg::TC_RESET;
      gap = tfl_pkg::GAP_RESET;
      y_last = '0;
      t_last = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [31:0] val);
      case (addr)
        ADDR_TC:  tc = val[15:0];
        ADDR_GAP: gap = val[15:0];
        default: ;
      endcase
    endfunction

    // weighted mean in offset binary, rounded to nearest with ties up
    function logic [31:0] blend_q16(logic [31:0] prev, logic [31:0] x, logic [63:0] alpha);
      logic [63:0] one;
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] acc;
      logic [63:0] r;
      one = 64'd1 << FRAC;
      p = {32'd0, prev ^ 32'h8000_0000};
      q = {32'd0, x ^ 32'h8000_0000};
      if (alpha > one) alpha = one;
      acc = alpha * p + (one - alpha) * q + (one >> 1);
      r = acc >> FRAC;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      return r[31:0] ^ 32'h8000_0000;
    endfunction

    function void note_sample(tfl_pkg::in_item_t it);
      tfl_pkg::out_item_t want;
      logic [31:0] dt;
      logic [63:0] t64;
      logic [63:0] den;
      logic [63:0] alpha;
      dt = it.now_ms - t_last;
      if (dt == 0) begin
        want.filtered = y_last;
        want.outcome = tfl_pkg::OUTC_HELD;
      end else if (dt > {16'd0, gap}) begin
        y_last = it.sample;
        t_last = it.now_ms;
        want.filtered = it.sample;
        want.outcome = tfl_pkg::OUTC_RESTART;
      end else begin
        t64 = {48'd0, tc};
        den = t64 + {32'd0, dt};
        alpha = ((t64 << FRAC) + (den >> 1)) / den;
        y_last = blend_q16(y_last, it.sample, alpha);
        t_last = it.now_ms;
        want.filtered = y_last;
        want.outcome = tfl_pkg::OUTC_FILTERED;
      end
      predicted_outputs.push_back(want);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_output(tfl_pkg::out_item_t got);
      tfl_pkg::out_item_t want;
      if (predicted_outputs.size() == 0) begin
        report_mismatch($sformatf("output transaction with nothing pending: %h", got));
        return;
      end
      want = predicted_outputs.pop_front();
      if (got.filtered !== want.filtered)
        report_mismatch($sformatf("filtered got %h want %h", got.filtered, want.filtered));
      if (got.outcome !== want.outcome)
        report_mismatch($sformatf("outcome got %0d want %0d", got.outcome, want.outcome));
    endtask

    function int pending_count();
      return predicted_outputs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  tfl_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_ready;
  tfl_pkg::out_item_t out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lowpass_scoreboard sb;
  int          tx_pct;        // percent of cycles the sender stays idle
  int          rx_pct;        // percent of cycles the receiver stalls
  logic        hold_req;      // asks the receiver for one long hold-off
  logic [31:0] last_tick;     // tick of the last generated transaction
  int          stall_cycles;

  timed_first_order_lowpass_core #(
    .ALPHA_FRAC_BITS(FRAC)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request so the block backs up
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_pct);
    end
  end

  // every result transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_data);
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // offers one input transaction, with random idle cycles before it, until accepted
  task automatic send_item(input tfl_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(it);
  endtask

  task automatic send_pair(input logic [31:0] s, input logic [31:0] n);
    tfl_pkg::in_item_t it;
    it.sample = s;
    it.now_ms = n;
    last_tick = n;
    send_item(it);
  endtask

  // sender goes quiet until every predicted result has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_reg(input logic [2:0] addr, input logic [15:0] val);
    logic [31:0] word;
    word = {16'($urandom()), val};  // upper bits are ignored by the 16-bit registers
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(addr, word);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // random transaction: mostly small forward steps within the gap, so the filter runs
  task automatic next_item(output tfl_pkg::in_item_t it);
    logic [31:0] dt;
    logic [19:0] r;
    int unsigned span;
    int unsigned pick;
    span = (sb.gap == 0) ? 1 : sb.gap;
    r = 20'($urandom());
    case ($urandom_range(0, 5))
      0: it.sample = 32'h7FFF_FFFF;
      1: it.sample = 32'h8000_0000;
      2, 3: it.sample = $urandom();
      default: it.sample = {{12{r[19]}}, r};
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 10) dt = 0;                                         // no time passed
    else if (pick < 50) dt = $urandom_range(1, (span < 64) ? span : 64);
    else if (pick < 78) dt = $urandom_range(1, span);
    else if (pick < 86) dt = span + $urandom_range(0, 1);          // right at the gap edge
    else if (pick < 93) dt = $urandom();                           // far jump, may wrap
    else dt = -$urandom_range(1, 1000);                            // clock went backwards
    it.now_ms = last_tick + dt;
    last_tick = it.now_ms;
  endtask

  initial begin
    tfl_pkg::in_item_t it;
    logic [15:0] tc_val;
    logic [15:0] gap_val;
    int          n_items;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_pct = 0;
    rx_pct = 0;
    hold_req = 1'b0;
    last_tick = '0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset settings (tc 10, gap 300)
    send_pair(32'h7FFF_FFFF, 32'd0);          // no time since reset: held zero
    send_pair(32'h7FFF_FFFF, 32'd1);          // smallest step
    send_pair(32'h8000_0000, 32'd2);
    send_pair(32'h8000_0000, 32'd2);          // held
    send_pair(32'h1234_5678, 32'd302);        // dt equal to the gap still filters
    send_pair(32'hEDCB_A987, 32'd603);        // one past the gap restarts
    send_pair(32'h7FFF_FFFF, 32'hFFFF_FFFF);  // huge jump
    send_pair(32'h8000_0000, 32'd0);          // step across the wrap
    send_pair(32'h0000_0001, 32'hFFFF_FF00);  // backwards: restart
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FF01);
    send_pair(32'h5555_5555, 32'hFFFF_FF40);
    send_pair(32'hAAAA_AAAA, 32'hFFFF_FF40);  // held after a filtered update
    send_pair(32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h8000_012C);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: begin tc_val = 16'd0;     gap_val = 16'hFFFF; n_items = 100; end  // zero tc
        1: begin tc_val = 16'hFFFF;  gap_val = 16'hFFFF; n_items = 120; end
        2: begin tc_val = 16'hFFFF;  gap_val = 16'd1;    n_items = 80;  end
        3: begin tc_val = 16'd1;     gap_val = 16'd1;    n_items = 80;  end
        4: begin tc_val = 16'd200;   gap_val = 16'd0;    n_items = 60;  end  // gap zero
        5: begin
          tc_val = tfl_pkg::TC_RESET;
          gap_val = tfl_pkg::GAP_RESET;
          n_items = 150;
        end
        10: begin tc_val = 16'd1;    gap_val = 16'hFFFF; n_items = 100; end
        11: begin
          tc_val = 16'($urandom());
          gap_val = 16'($urandom_range(1, 50));
          n_items = 100;
        end
        default: begin
          tc_val = 16'($urandom());
          gap_val = 16'($urandom_range(1, 65535));
          n_items = 100;
        end
      endcase
      write_reg(ADDR_TC, tc_val);
      write_reg(ADDR_GAP, gap_val);

      // idle mix rotates: none, sender idle, receiver stall, both lightly
      case (p % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 72; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 72; end
        default: begin tx_pct = 22; rx_pct = 22; end
      endcase

      for (int i = 0; i < n_items; i++) begin
        if (p == 1 && i == 40) hold_req = 1'b1;  // block fills up and stalls its input
        if (p == 5 && i == 60) drain();          // sender waits for every result
        next_item(it);
        send_item(it);
      end
    end

    drain();
    if (sb.pending_count() != 0)
      sb.report_mismatch($sformatf("%0d results never came", sb.pending_count()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
